// ===== rtl/bfm_pkg.sv =====
// Shared types and constants for the box filter mean unit.
package bfm_pkg;

	localparam int unsigned PIX_W    = 8;
	localparam int unsigned COLSUM_W = 14;
	localparam int unsigned WINSUM_W = 19;
	localparam int unsigned CFG_W    = 6;
	localparam int unsigned DIM_W    = 11;
	localparam int unsigned POS_W    = 10;
	localparam int unsigned KK_W     = 11;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} pos_t;

endpackage

// ===== rtl/box_filter_mean_unit.sv =====
// Top level of the k-by-k box mean filter over a raster pixel stream.
//
//  channel | direction | handshake        | payload
//  in      | input     | valid / ready    | pixel, frame_start
//  out     | output    | out_valid/out_ready | mean_value, out_row, out_col, frame_done
//  cfg     | input     | APB psel/penable | paddr, pwdata, prdata
//
// A pixel that completes a window passes through accept, line store and column sum read with
// write-back, the delayed column sum and the divider start, the divider (19 steps and the
// rounding), and the load of the output register. A pixel that completes no window skips
// the divider and returns to idle from the divider start state.
// Reset clears control state and the window sum; column sums in row zero are ignored,
// so no clearing pass is needed. A result waits in the output register while the
// next pixel is processed; a new result stalls only if the register is still full.
module box_filter_mean_unit import bfm_pkg::*; #(
	parameter int unsigned MAX_WINDOW = 39,
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  mean_value,
	output logic [POS_W-1:0]  out_row,
	output logic [POS_W-1:0]  out_col,
	output logic              frame_done,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned RW   = $clog2(MAX_HEIGHT);
	localparam int unsigned KW   = $clog2(MAX_WINDOW + 1);
	localparam int unsigned LS_D = MAX_WINDOW * MAX_WIDTH;
	localparam int unsigned LS_A = $clog2(LS_D);
	localparam int unsigned WCW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HCW  = $clog2(MAX_HEIGHT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_OLD  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [CFG_W-1:0] win_q;
	logic [DIM_W-1:0] wid_q;
	logic [DIM_W-1:0] hgt_q;
	logic [KW-1:0]    k;
	logic [WCW-1:0]   w;
	logic [HCW-1:0]   h;

	logic [2:0]          state_q;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       r_q;
	logic [CW-1:0]       c_q;
	logic [KW-1:0]       slot_q;
	logic [PIX_W-1:0]    px_q;
	logic [WINSUM_W-1:0] wsum_q;
	logic                emit_q;
	pos_t                pos_q;
	logic                ov_q;
	logic [PIX_W-1:0]    mean_q;
	pos_t                opos_q;
	logic                load_out;

	logic [RW-1:0]       r_in;
	logic [CW-1:0]       c_in;
	logic [KW-1:0]       slot_in;
	logic                acc;

	logic                ls_we;
	logic [LS_A-1:0]     ls_addr_r;
	logic [LS_A-1:0]     ls_addr_w;
	logic [PIX_W-1:0]    ls_rd;
	logic                cs_we;
	logic [CW-1:0]       cs_raddr;
	logic [COLSUM_W-1:0] cs_wdata;
	logic [COLSUM_W-1:0] cs_rd;
	logic [COLSUM_W-1:0] cs_new;

	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [PIX_W-1:0]    div_q;
	logic [KK_W-1:0]     kk;

	always_comb begin
		logic [CFG_W-1:0] kt;
		kt = win_q;
		if (kt > CFG_W'(MAX_WINDOW)) begin
			kt = CFG_W'(MAX_WINDOW);
		end
		if (kt == '0) begin
			kt = CFG_W'(1);
		end
		if (!kt[0]) begin
			kt = kt - 1'b1;
		end
		k = KW'(kt);
		w = (wid_q == '0) ? WCW'(1) :
			((wid_q > DIM_W'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(wid_q));
		h = (hgt_q == '0) ? HCW'(1) :
			((hgt_q > DIM_W'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : HCW'(hgt_q));
	end

	assign kk = KK_W'(k) * KK_W'(k);

	always_comb begin
		r_in = row_q;
		c_in = col_q;
		if (frame_start) begin
			r_in = '0;
			c_in = '0;
		end else begin
			if ({1'b0, col_q} >= WCW'(w)) begin
				c_in = '0;
				r_in = row_q + 1'b1;
			end
			if ({1'b0, r_in} >= HCW'(h)) begin
				r_in = '0;
			end
		end
	end

	// The slot row advances with the row and wraps at k.
	logic [KW-1:0] slot_row_q;
	always_comb begin
		slot_in = slot_row_q;
		if (r_in == '0) begin
			slot_in = '0;
		end else if (r_in != r_q) begin
			slot_in = (slot_row_q + 1'b1 >= k) ? '0 : slot_row_q + 1'b1;
		end
	end

	assign ready = (state_q == ST_IDLE);
	assign acc   = valid && ready;

	assign ls_addr_r = LS_A'(slot_in * MAX_WIDTH + c_in);
	assign ls_addr_w = LS_A'(slot_q * MAX_WIDTH + c_q);
	assign ls_we     = (state_q == ST_RD);

	assign cs_new = COLSUM_W'(((r_q == '0) ? '0 : cs_rd) + COLSUM_W'(px_q)
		- ((RW'(r_q) >= RW'(k)) ? COLSUM_W'(ls_rd) : '0));

	assign cs_we    = (state_q == ST_RD);
	assign cs_wdata = cs_new;
	assign cs_raddr = (state_q == ST_IDLE) ? c_in : CW'(c_q - CW'(k));

	bfm_ram #(.WIDTH(PIX_W), .DEPTH(LS_D)) u_line (
		.clk  (clk),
		.we   (ls_we),
		.waddr(ls_addr_w),
		.wdata(px_q),
		.re   (acc),
		.raddr(ls_addr_r),
		.rdata(ls_rd)
	);

	bfm_ram #(.WIDTH(COLSUM_W), .DEPTH(MAX_WIDTH)) u_cols (
		.clk  (clk),
		.we   (cs_we),
		.waddr(c_q),
		.wdata(cs_wdata),
		.re   (acc || state_q == ST_RD),
		.raddr(cs_raddr),
		.rdata(cs_rd)
	);

	assign div_start = (state_q == ST_OLD) && emit_q;

	bfm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(wsum_q),
		.divisor (kk),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_q)
	);

	assign load_out = (state_q == ST_OUT) && (!ov_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_q      <= '0;
			col_q      <= '0;
			slot_row_q <= '0;
			wsum_q     <= '0;
			ov_q       <= 1'b0;
			win_q      <= CFG_W'(3);
			wid_q      <= DIM_W'(640);
			hgt_q      <= DIM_W'(480);
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_WINDOW: win_q <= pwdata[CFG_W-1:0];
					REG_WIDTH:  wid_q <= pwdata[DIM_W-1:0];
					REG_HEIGHT: hgt_q <= pwdata[DIM_W-1:0];
					default: ;
				endcase
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q    <= ST_RD;
						slot_row_q <= slot_in;
						if ({1'b0, c_in} + 1'b1 >= WCW'(w)) begin
							col_q <= '0;
							row_q <= ({1'b0, r_in} + 1'b1 >= HCW'(h)) ? '0 : r_in + 1'b1;
						end else begin
							col_q <= c_in + 1'b1;
							row_q <= r_in;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_SUM;
					wsum_q  <= WINSUM_W'(((c_q == '0) ? '0 : wsum_q) + WINSUM_W'(cs_new));
				end
				ST_SUM: begin
					state_q <= ST_OLD;
					if (CW'(c_q) >= CW'(k)) begin
						wsum_q <= wsum_q - WINSUM_W'(cs_rd);
					end
				end
				ST_OLD: begin
					state_q <= emit_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			r_q    <= r_in;
			c_q    <= c_in;
			slot_q <= slot_in;
			px_q   <= pixel;
			emit_q <= ({1'b0, r_in} + 1'b1 >= (RW+1)'(k)) &&
				({1'b0, c_in} + 1'b1 >= (CW+1)'(k));
			pos_q.row  <= POS_W'(r_in + 1'b1 - RW'(k));
			pos_q.col  <= POS_W'(c_in + 1'b1 - CW'(k));
			pos_q.last <= ({1'b0, r_in} == HCW'(h - 1'b1)) &&
				({1'b0, c_in} == WCW'(w - 1'b1));
		end
		if (load_out) begin
			mean_q <= div_q;
			opos_q <= pos_q;
		end
	end

	assign out_valid  = ov_q;
	assign mean_value = mean_q;
	assign out_row    = opos_q.row;
	assign out_col    = opos_q.col;
	assign frame_done = opos_q.last;
	assign pready     = 1'b1;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_WINDOW: prdata = 32'(win_q);
			REG_WIDTH:  prdata = 32'(wid_q);
			REG_HEIGHT: prdata = 32'(hgt_q);
			default:    prdata = '0;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> !div_busy)
		else $error("input taken while divider busy");
	a_div_emit: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> emit_q)
		else $error("divider started for non-emitting pixel");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(mean_value))
		else $error("result lost while stalled");

endmodule

// ===== rtl/bfm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module bfm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bfm_div.sv =====
// Sequential restoring divider with round-half-even and saturation at 255.
module bfm_div import bfm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WINSUM_W-1:0] dividend,
	input  logic [KK_W-1:0]     divisor,
	output logic                busy,
	output logic                done,
	output logic [PIX_W-1:0]    quotient
);

	localparam int unsigned CNT_W = $clog2(WINSUM_W + 2);

	logic [WINSUM_W-1:0] q_q;
	logic [KK_W:0]       r_q;
	logic [KK_W-1:0]     d_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                fin_q;
	logic [KK_W+1:0]     trial;
	logic [KK_W+1:0]     twice_r;
	logic                up;
	logic [WINSUM_W:0]   qr;

	assign trial   = {r_q, q_q[WINSUM_W-1]};
	assign twice_r = {r_q, 1'b0};
	assign up      = (twice_r > {2'b00, d_q}) || ((twice_r == {2'b00, d_q}) && q_q[0]);
	assign qr      = {1'b0, q_q} + {{WINSUM_W{1'b0}}, up};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(WINSUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			if (trial >= {1'b0, 1'b0, d_q}) begin
				r_q <= (KK_W+1)'(trial - {2'b00, d_q});
				q_q <= {q_q[WINSUM_W-2:0], 1'b1};
			end else begin
				r_q <= trial[KK_W:0];
				q_q <= {q_q[WINSUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = run_q || fin_q;
	assign done     = fin_q;
	assign quotient = (qr > (WINSUM_W+1)'(255)) ? 8'hFF : qr[PIX_W-1:0];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the k-by-k box mean filter with a built-in predictor.
module testbench;
	import bfm_pkg::*;

	localparam int unsigned LIM_K = 39;
	localparam int unsigned LIM_D = 1024;
	localparam int unsigned WATCHDOG = 20000;

	typedef struct {
		logic [PIX_W-1:0] mean;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} window_result_t;

	typedef struct {
		int unsigned      k;
		int unsigned      w;
		int unsigned      h;
		logic [PIX_W-1:0] px;
		logic             fs;
		bit               typed;
		logic [PIX_W-1:0] mean;
	} pixel_row_t;

	logic              clk;
	logic              arst_n;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  pixel;
	logic              frame_start;
	logic              out_valid;
	logic              out_ready;
	logic [PIX_W-1:0]  mean_value;
	logic [POS_W-1:0]  out_row;
	logic [POS_W-1:0]  out_col;
	logic              frame_done;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	box_filter_mean_unit u_top (.*);

	logic [PIX_W-1:0]    pix_hist [LIM_K*LIM_D];
	logic [COLSUM_W-1:0] col_sum [LIM_D];
	logic [WINSUM_W-1:0] win_sum;
	int unsigned         cur_row, cur_col;
	logic [CFG_W-1:0]    cfg_k;
	logic [DIM_W-1:0]    cfg_w, cfg_h;

	window_result_t pending_means[$];
	int  errors;
	int  idle_cycles;
	bit  calm;
	int  out_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void report(string what, int unsigned exp_v, int unsigned act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
	endfunction

	function automatic int unsigned window_side();
		int unsigned k;
		k = cfg_k;
		if (k > LIM_K) k = LIM_K;
		if (k == 0) k = 1;
		if (k[0] == 1'b0) k = k - 1;
		return k;
	endfunction

	function automatic int unsigned dim(int unsigned v);
		if (v == 0) return 1;
		return (v > LIM_D) ? LIM_D : v;
	endfunction

	function automatic void predict_mean(logic [PIX_W-1:0] px, logic fs, bit typed,
			logic [PIX_W-1:0] typed_mean);
		int unsigned k, w, h, slot, cs, q, rem, d;
		window_result_t res;
		k = window_side();
		w = dim(cfg_w);
		h = dim(cfg_h);
		if (fs) begin
			cur_row = 0;
			cur_col = 0;
		end
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= h) cur_row = 0;
		slot = (cur_row % k) * LIM_D + cur_col;
		cs = (cur_row == 0) ? 0 : col_sum[cur_col];
		cs += px;
		if (cur_row >= k) cs -= pix_hist[slot];
		col_sum[cur_col] = cs[COLSUM_W-1:0];
		pix_hist[slot] = px;
		if (cur_col == 0) win_sum = '0;
		win_sum = win_sum + col_sum[cur_col];
		if (cur_col >= k) win_sum = win_sum - col_sum[cur_col-k];
		if (cur_row + 1 >= k && cur_col + 1 >= k) begin
			d = k * k;
			q = win_sum / d;
			rem = win_sum % d;
			if (2*rem > d || (2*rem == d && q[0])) q++;
			res.mean = (q > 255) ? 8'd255 : q[7:0];
			if (typed) res.mean = typed_mean;
			res.row = POS_W'(cur_row + 1 - k);
			res.col = POS_W'(cur_col + 1 - k);
			res.done = (cur_row == h - 1 && cur_col == w - 1);
			pending_means.push_back(res);
		end
		cur_col++;
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= h) cur_row = 0;
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		window_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_means.size() == 0) begin
				report("unexpected transaction", 0, 1);
			end else begin
				e = pending_means.pop_front();
				if (mean_value !== e.mean) report("mean_value", e.mean, mean_value);
				if (out_row !== e.row) report("out_row", e.row, out_row);
				if (out_col !== e.col) report("out_col", e.col, out_col);
				if (frame_done !== e.done) report("frame_done", e.done, frame_done);
			end
		end
		if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			out_ready <= 1'b0;
		end else begin
			out_stall <= gap_len();
			out_ready <= 1'b1;
		end
	end

	task automatic send_pixel(logic [PIX_W-1:0] px, logic fs, bit typed = 0,
			logic [PIX_W-1:0] typed_mean = '0);
		int g;
		valid <= 1'b1;
		pixel <= px;
		frame_start <= fs;
		do @(posedge clk); while (!ready);
		predict_mean(px, fs, typed, typed_mean);
		g = gap_len();
		if (g > 0) begin
			valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic apb_access(logic [1:0] idx, logic wr, logic [31:0] data);
		logic [31:0] mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		mask = (idx == REG_WINDOW) ? 32'h3f : 32'h7ff;
		if (!wr && (prdata & mask) !== (data & mask))
			report("register read", data & mask, prdata & mask);
	endtask

	task automatic configure(int unsigned k, int unsigned w, int unsigned h);
		valid <= 1'b0;
		wait (pending_means.size() == 0);
		repeat (64) @(posedge clk);
		apb_access(REG_WINDOW, 1'b1, k);
		apb_access(REG_WIDTH, 1'b1, w);
		apb_access(REG_HEIGHT, 1'b1, h);
		apb_access(REG_WINDOW, 1'b0, k);
		apb_access(REG_WIDTH, 1'b0, w);
		apb_access(REG_HEIGHT, 1'b0, h);
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_k = k[CFG_W-1:0];
		cfg_w = w[DIM_W-1:0];
		cfg_h = h[DIM_W-1:0];
	endtask

	pixel_row_t directed[$];

	task automatic add_row(int unsigned k, int unsigned w, int unsigned h, int unsigned px,
			bit fs, bit typed = 0, int unsigned m = 0);
		pixel_row_t r;
		r.k = k; r.w = w; r.h = h; r.px = px[PIX_W-1:0]; r.fs = fs; r.typed = typed;
		r.mean = m[PIX_W-1:0];
		directed.push_back(r);
	endtask

	initial begin
		int unsigned k, w, h, frames, items, n;
		bit noise;
		arst_n = 1'b0;
		valid = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		idle_cycles = 0;
		calm = 0;
		out_stall = 0;
		win_sum = '0;
		cur_row = 0;
		cur_col = 0;
		cfg_k = 6'd3;
		cfg_w = 11'd640;
		cfg_h = 11'd480;
		foreach (col_sum[i]) col_sum[i] = '0;
		foreach (pix_hist[i]) pix_hist[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(1, 2, 2, 0, 1, 1, 0);
		add_row(1, 2, 2, 255, 0, 1, 255);
		add_row(1, 2, 2, 1, 0, 1, 1);
		add_row(1, 2, 2, 128, 0, 1, 128);
		for (int i = 0; i < 9; i++) add_row(3, 3, 3, 255, i == 0, i == 8, 255);
		add_row(0, 0, 0, 7, 1, 1, 7);
		add_row(0, 0, 0, 200, 0, 1, 200);
		add_row(2, 3, 1, 17, 1, 1, 17);
		add_row(2, 3, 1, 0, 0, 1, 0);
		add_row(2, 3, 1, 255, 0, 1, 255);
		for (int i = 0; i < 4; i++) add_row(63, 3, 3, i * 60, i == 0);
		add_row(5, 2047, 2047, 9, 1);
		foreach (directed[i]) begin
			if (i == 0 || directed[i].k != directed[i-1].k || directed[i].w != directed[i-1].w
					|| directed[i].h != directed[i-1].h)
				configure(directed[i].k, directed[i].w, directed[i].h);
			send_pixel(directed[i].px, directed[i].fs, directed[i].typed, directed[i].mean);
		end

		configure(15, 15, 15);
		for (int i = 0; i < 15*15; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
		configure(1, 2047, 2);
		for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
		configure(1, 1, 2047);
		for (int i = 0; i < 40; i++) send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);

		items = 0;
		while (items < 450) begin
			calm = ($urandom_range(0, 4) == 0);
			k = 2 * $urandom_range(0, 3) + 1;
			if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 15);
			w = $urandom_range(k, k + 6);
			h = $urandom_range(k, k + 3);
			if ($urandom_range(0, 15) == 0) w = 0;
			if ($urandom_range(0, 15) == 0) h = 0;
			configure(k, w, h);
			frames = $urandom_range(1, 2);
			for (int f = 0; f < frames; f++) begin
				n = dim(w) * dim(h);
				noise = ($urandom_range(0, 7) == 0);
				if (noise) n = $urandom_range(1, n);
				for (int i = 0; i < n; i++) begin
					send_pixel(PIX_W'(($urandom_range(0, 9) == 0) ? 255 :
						$urandom_range(0, 255)),
						(i == 0 && (f == 0 || $urandom_range(0, 1))) ||
						(noise && $urandom_range(0, 30) == 0));
					items++;
				end
				if (noise) begin
					send_pixel(PIX_W'($urandom_range(0, 255)), 1'b1);
					items++;
					n = dim(w) * dim(h) - 1;
					for (int i = 0; i < n; i++)
						send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
					items += n;
				end
			end
		end

		valid <= 1'b0;
		calm = 0;
		wait (pending_means.size() == 0);
		repeat (64) @(posedge clk);
		if (errors == 0 && pending_means.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== box_filter_mean_unit.f =====
rtl/bfm_pkg.sv
rtl/bfm_ram.sv
rtl/bfm_div.sv
rtl/box_filter_mean_unit.sv
tb/testbench.sv
